>>> design/a64dec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a64dec_pkg: shared types and encodings for the AArch64 subset decoder
// Instruction pattern masks, kind codes, result record and register coding.
// ----------------------------------------------------------------------------
package a64dec_pkg;

    // result kinds
    typedef enum logic [3:0] {
        KIND_ADRP = 4'd0,
        KIND_MOV  = 4'd1,
        KIND_MOVZ = 4'd2,
        KIND_MOVN = 4'd3,
        KIND_MOVK = 4'd4,
        KIND_STR  = 4'd5,
        KIND_STRH = 4'd6,
        KIND_STRB = 4'd7,
        KIND_LDR  = 4'd8,
        KIND_STP  = 4'd9,
        KIND_ADD  = 4'd10,
        KIND_SUB  = 4'd11,
        KIND_BL   = 4'd12,
        KIND_B    = 4'd13
    } kind_t;

    // pattern masks and match values
    localparam logic [31:0] ADRP_MASK    = 32'h9F00_0000;
    localparam logic [31:0] ADRP_VAL     = 32'h9000_0000;
    localparam logic [31:0] MOV_MASK     = 32'h7FE0_FFE0;
    localparam logic [31:0] MOV_VAL      = 32'h2A00_03E0;
    localparam logic [31:0] MOVW_MASK    = 32'h1F80_0000;
    localparam logic [31:0] MOVW_VAL     = 32'h1280_0000;
    localparam logic [31:0] TOP_MASK     = 32'hFFC0_0000;
    localparam logic [31:0] STR_W_VAL    = 32'hB900_0000;
    localparam logic [31:0] STR_X_VAL    = 32'hF900_0000;
    localparam logic [31:0] STRH_VAL     = 32'h7900_0000;
    localparam logic [31:0] STRB_VAL     = 32'h3900_0000;
    localparam logic [31:0] LDR_W_VAL    = 32'hB940_0000;
    localparam logic [31:0] LDR_X_VAL    = 32'hF940_0000;
    localparam logic [31:0] LDR_D_VAL    = 32'hFD40_0000;
    localparam logic [31:0] BR_MASK      = 32'hFC00_0000;
    localparam logic [31:0] BL_VAL       = 32'h9400_0000;
    localparam logic [31:0] B_VAL        = 32'h1400_0000;
    localparam logic [31:0] ADDSUB_MASK  = 32'h7F80_0000;
    localparam logic [31:0] ADD_VAL      = 32'h1100_0000;
    localparam logic [31:0] SUB_VAL      = 32'h5100_0000;
    localparam logic [31:0] STP_W_VAL    = 32'h2900_0000;
    localparam logic [31:0] STP_X_VAL    = 32'hA900_0000;

    // move-wide opc values
    localparam logic [1:0] OPC_MOVN = 2'b00;
    localparam logic [1:0] OPC_BAD  = 2'b01;
    localparam logic [1:0] OPC_MOVZ = 2'b10;

    localparam logic [63:0] LOW_WORD_MASK = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] PAGE_MASK     = 64'hFFFF_FFFF_FFFF_F000;

    typedef struct packed {
        logic        decoded;
        kind_t       kind;
        logic [6:0]  dest_reg;
        logic [6:0]  base_reg;
        logic [6:0]  second_reg;
        logic [63:0] immediate;
        logic [5:0]  shift_amount;
    } dec_result_t;

    // register code: [4:0] number, [5] 32-bit view, [6] stack pointer
    function automatic logic [6:0] reg_code(input logic [4:0] num, input logic is64,
                                            input logic sp_ok);
        reg_code = {sp_ok && (num == 5'd31), !is64, num};
    endfunction

endpackage
`default_nettype wire

>>> design/arm64_instruction_subset_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm64_instruction_subset_decoder_top: AArch64 instruction subset decoder
// Decodes ADRP, MOV, move-wide, load/store, branch, ADD/SUB and STP words.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+-------------------
//  s_      | in  | [31:0] instruction_word,                | -
//          |     | [95:32] program_counter                 |
//  m_      | out | [6:0] dest_reg, [13:7] base_reg,        | [0] decoded,
//          |     | [20:14] second_reg, [84:21] immediate,  | [4:1] kind
//          |     | [90:85] shift_amount, [95:91] zero      |
//
//  One beat in, one beat out. Each beat passes the input register, then
//  decode logic and the 64-bit target adder into the result register.
//  Throughput is one beat per cycle unless the output stalls; the single
//  target adder sets the path. A stalled output holds its beat; the input
//  register keeps taking beats while the result register can move on.
//  aresetn is synchronous, active low, and clears both valid flags only.
//
module arm64_instruction_subset_decoder_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // [31:0] instruction_word, [95:32] program_counter
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // [6:0] dest, [13:7] base, [20:14] second,
                                         // [84:21] immediate, [90:85] shift, rest 0
    output logic [4:0]        m_tuser    // [0] decoded, [4:1] kind
);

    // ---------------- input register ----------------
    logic        in_valid_reg, in_valid_next;
    logic [31:0] word_reg;
    logic [63:0] pc_reg;

    logic        out_valid_reg, out_valid_next;
    a64dec_pkg::dec_result_t out_reg, out_next;

    logic out_ready;   // result register can take a new beat
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            word_reg <= s_tdata[31:0];
            pc_reg   <= s_tdata[95:32];
        end
        if (out_ready && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    // ---------------- decode ----------------
    logic [4:0]  rt, rn, rm, rt2;
    logic        sf;
    logic [11:0] imm12;
    logic [15:0] imm16;
    logic [1:0]  opc;
    logic [5:0]  mw_shift;
    logic [63:0] mw_shifted;
    logic [20:0] adrp_off;
    logic [6:0]  stp_off;
    logic        is_adrp, is_mov, is_movw, is_br, is_addsub, is_stp_w, is_stp_x;
    logic [31:0] top_bits;
    logic [63:0] add_a, add_b, target;

    assign rt       = word_reg[4:0];
    assign rn       = word_reg[9:5];
    assign rm       = word_reg[20:16];
    assign rt2      = word_reg[14:10];
    assign sf       = word_reg[31];
    assign imm12    = word_reg[21:10];
    assign imm16    = word_reg[20:5];
    assign opc      = word_reg[30:29];
    assign mw_shift = {word_reg[22:21], 4'b0000};
    assign adrp_off = {word_reg[23:5], word_reg[30:29]};
    assign stp_off  = word_reg[21:15];
    assign top_bits = word_reg & a64dec_pkg::TOP_MASK;

    assign is_adrp   = (word_reg & a64dec_pkg::ADRP_MASK) == a64dec_pkg::ADRP_VAL;
    assign is_mov    = (word_reg & a64dec_pkg::MOV_MASK) == a64dec_pkg::MOV_VAL;
    assign is_movw   = (word_reg & a64dec_pkg::MOVW_MASK) == a64dec_pkg::MOVW_VAL;
    assign is_br     = ((word_reg & a64dec_pkg::BR_MASK) == a64dec_pkg::BL_VAL) ||
                       ((word_reg & a64dec_pkg::BR_MASK) == a64dec_pkg::B_VAL);
    assign is_addsub = ((word_reg & a64dec_pkg::ADDSUB_MASK) == a64dec_pkg::ADD_VAL) ||
                       ((word_reg & a64dec_pkg::ADDSUB_MASK) == a64dec_pkg::SUB_VAL);
    assign is_stp_w  = top_bits == a64dec_pkg::STP_W_VAL;
    assign is_stp_x  = top_bits == a64dec_pkg::STP_X_VAL;

    assign mw_shifted = {48'd0, imm16} << mw_shift;

    // one shared adder for ADRP page and branch targets
    assign add_a  = is_adrp ? (pc_reg & a64dec_pkg::PAGE_MASK) : pc_reg;
    assign add_b  = is_adrp ? {{31{adrp_off[20]}}, adrp_off, 12'd0}
                            : {{36{word_reg[25]}}, word_reg[25:0], 2'b00};
    assign target = add_a + add_b;

    always_comb begin
        out_next = '0;
        if (is_adrp) begin
            out_next.decoded   = 1'b1;
            out_next.kind      = a64dec_pkg::KIND_ADRP;
            out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b1, 1'b0);
            out_next.immediate = target;
        end else if (is_mov) begin
            out_next.decoded   = 1'b1;
            out_next.kind      = a64dec_pkg::KIND_MOV;
            out_next.dest_reg  = a64dec_pkg::reg_code(rt, sf, 1'b0);
            out_next.base_reg  = a64dec_pkg::reg_code(rm, sf, 1'b0);
        end else if (is_movw) begin
            // opc 01 ends the search with no match
            if (opc != a64dec_pkg::OPC_BAD) begin
                out_next.decoded      = 1'b1;
                out_next.dest_reg     = a64dec_pkg::reg_code(rt, sf, 1'b0);
                out_next.shift_amount = mw_shift;
                if (opc == a64dec_pkg::OPC_MOVN) begin
                    out_next.kind      = a64dec_pkg::KIND_MOVN;
                    out_next.immediate = ~mw_shifted &
                                         (sf ? '1 : a64dec_pkg::LOW_WORD_MASK);
                end else if (opc == a64dec_pkg::OPC_MOVZ) begin
                    out_next.kind      = a64dec_pkg::KIND_MOVZ;
                    out_next.immediate = mw_shifted;
                end else begin
                    out_next.kind      = a64dec_pkg::KIND_MOVK;
                    out_next.immediate = {48'd0, imm16};
                end
            end
        end else begin
            out_next.decoded  = 1'b1;
            out_next.base_reg = a64dec_pkg::reg_code(rn, 1'b1, 1'b1);
            unique case (top_bits) inside
                a64dec_pkg::STR_W_VAL: begin
                    out_next.kind      = a64dec_pkg::KIND_STR;
                    out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b0, 1'b0);
                    out_next.immediate = {50'd0, imm12, 2'b00};
                end
                a64dec_pkg::STR_X_VAL: begin
                    out_next.kind      = a64dec_pkg::KIND_STR;
                    out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b1, 1'b0);
                    out_next.immediate = {49'd0, imm12, 3'b000};
                end
                a64dec_pkg::STRH_VAL: begin
                    out_next.kind      = a64dec_pkg::KIND_STRH;
                    out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b0, 1'b0);
                    out_next.immediate = {51'd0, imm12, 1'b0};
                end
                a64dec_pkg::STRB_VAL: begin
                    out_next.kind      = a64dec_pkg::KIND_STRB;
                    out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b0, 1'b0);
                    out_next.immediate = {52'd0, imm12};
                end
                a64dec_pkg::LDR_W_VAL: begin
                    out_next.kind      = a64dec_pkg::KIND_LDR;
                    out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b0, 1'b0);
                    out_next.immediate = {50'd0, imm12, 2'b00};
                end
                a64dec_pkg::LDR_X_VAL, a64dec_pkg::LDR_D_VAL: begin
                    out_next.kind      = a64dec_pkg::KIND_LDR;
                    out_next.dest_reg  = a64dec_pkg::reg_code(rt, 1'b1, 1'b0);
                    out_next.immediate = {49'd0, imm12, 3'b000};
                end
                default: begin
                    out_next.base_reg = '0;
                    if (is_br) begin
                        out_next.kind      = sf ? a64dec_pkg::KIND_BL : a64dec_pkg::KIND_B;
                        out_next.immediate = target;
                    end else if (is_addsub) begin
                        out_next.kind      = word_reg[30] ? a64dec_pkg::KIND_SUB
                                                          : a64dec_pkg::KIND_ADD;
                        out_next.dest_reg  = a64dec_pkg::reg_code(rt, sf, 1'b1);
                        out_next.base_reg  = a64dec_pkg::reg_code(rn, sf, 1'b1);
                        out_next.immediate = word_reg[22] ? {40'd0, imm12, 12'd0}
                                                          : {52'd0, imm12};
                    end else if (is_stp_w || is_stp_x) begin
                        out_next.kind       = a64dec_pkg::KIND_STP;
                        out_next.dest_reg   = a64dec_pkg::reg_code(rt, is_stp_x, 1'b0);
                        out_next.second_reg = a64dec_pkg::reg_code(rt2, is_stp_x, 1'b0);
                        out_next.base_reg   = a64dec_pkg::reg_code(rn, 1'b1, 1'b1);
                        out_next.immediate  = is_stp_x
                            ? {{54{stp_off[6]}}, stp_off, 3'b000}
                            : {{55{stp_off[6]}}, stp_off, 2'b00};
                    end else begin
                        out_next.decoded = 1'b0;
                    end
                end
            endcase
        end
    end

    // ---------------- result port ----------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.kind, out_reg.decoded};
    assign m_tdata  = {5'd0, out_reg.shift_amount, out_reg.immediate,
                       out_reg.second_reg, out_reg.base_reg, out_reg.dest_reg};

`ifndef SYNTHESIS
    // a miss carries an all-zero record
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_reg.decoded) |-> (m_tdata == '0 && m_tuser == '0))
        else $error("undecoded beat has non-zero fields");

    // a buffered input beat moves into a free result register
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> out_valid_reg)
        else $error("decoded beat lost between stages");

    // second register only for STP
    a_second_stp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.second_reg != '0) |-> (out_reg.kind == a64dec_pkg::KIND_STP))
        else $error("second register set outside STP");

    // shift only for move-wide kinds
    a_shift_mw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.shift_amount != '0) |->
        (out_reg.kind == a64dec_pkg::KIND_MOVZ || out_reg.kind == a64dec_pkg::KIND_MOVN ||
         out_reg.kind == a64dec_pkg::KIND_MOVK))
        else $error("shift amount set outside move-wide");

    // branches carry no registers
    a_branch_regs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_reg.kind == a64dec_pkg::KIND_B ||
                      out_reg.kind == a64dec_pkg::KIND_BL))
        |-> (out_reg.dest_reg == '0 && out_reg.base_reg == '0))
        else $error("branch beat carries register codes");
`endif

endmodule
`default_nettype wire

>>> test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the AArch64 subset decoder
// Feeds directed and random instruction beats through the stream input.
// Predicts each decode in the bench and compares every result beat field by
// field, in order.
// ----------------------------------------------------------------------------
module tb;
    import a64dec_pkg::*;

    // ------------------------------------------------------------------------
    // clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;    // [31:0] instruction_word, [95:32] program_counter
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;          // [6:0] dest, [13:7] base, [20:14] second,
                                   // [84:21] immediate, [90:85] shift, [95:91] zero
    logic [4:0]  m_tuser;          // [0] decoded, [4:1] kind

    always #6 aclk = ~aclk;

    arm64_instruction_subset_decoder_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    logic [95:0]  insn_backlog [$];   // beats waiting to be offered: {pc, word}
    dec_result_t  decode_fifo  [$];   // predicted decodes, oldest first
    int           n_insn_in   = 0;    // input beats accepted
    int           n_dec_out   = 0;    // result beats accepted
    int           n_errors    = 0;
    int           hold_cycles = 0;    // remaining cycles of the long output stall
    logic         hold_done   = 1'b0;
    logic         calm;               // neither side idles in this window

    assign calm = (n_insn_in >= 200) && (n_insn_in < 300);

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    // Register code: [4:0] number, [5] set for the 32-bit view, [6] set when
    // number 31 means the stack pointer rather than the zero register.
    function automatic logic [6:0] enc_reg(input logic [4:0] num, input logic x64,
                                           input logic sp_ok);
        logic [6:0] c;
        c = {2'b00, num};
        if (num == 5'd31 && sp_ok)
            c[6] = 1'b1;
        if (!x64)
            c[5] = 1'b1;
        return c;
    endfunction

    // First matching pattern wins; anything else decodes to an all-zero record.
    function automatic dec_result_t decode_word(input logic [31:0] w, input logic [63:0] pc);
        dec_result_t r;
        logic        sf;
        logic        x64;
        logic [31:0] top;
        logic [63:0] imm16;
        logic [63:0] imm12;
        logic [63:0] off;
        logic [5:0]  sh;
        int          scale;
        r     = '0;
        sf    = w[31];
        x64   = 1'b0;
        scale = 0;
        top   = w & TOP_MASK;
        imm16 = {48'd0, w[20:5]};
        imm12 = {52'd0, w[21:10]};
        sh    = {w[22:21], 4'd0};
        if ((w & ADRP_MASK) == ADRP_VAL) begin
            // 21-bit page offset, immhi:immlo
            off         = {{43{w[23]}}, w[23:5], w[30:29]};
            r.decoded   = 1'b1;
            r.kind      = KIND_ADRP;
            r.dest_reg  = enc_reg(w[4:0], 1'b1, 1'b0);
            r.immediate = (pc & PAGE_MASK) + (off << 12);
        end else if ((w & MOV_MASK) == MOV_VAL) begin
            r.decoded  = 1'b1;
            r.kind     = KIND_MOV;
            r.dest_reg = enc_reg(w[4:0], sf, 1'b0);
            r.base_reg = enc_reg(w[20:16], sf, 1'b0);
        end else if ((w & MOVW_MASK) == MOVW_VAL) begin
            // opc 01 is unallocated: no match, and no fall-through either
            if (w[30:29] != OPC_BAD) begin
                r.decoded      = 1'b1;
                r.dest_reg     = enc_reg(w[4:0], sf, 1'b0);
                r.shift_amount = sh;
                case (w[30:29])
                    OPC_MOVN: begin
                        r.kind      = KIND_MOVN;
                        r.immediate = ~(imm16 << sh) & (sf ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : LOW_WORD_MASK);
                    end
                    OPC_MOVZ: begin
                        r.kind      = KIND_MOVZ;
                        r.immediate = imm16 << sh;
                    end
                    default: begin
                        r.kind      = KIND_MOVK;
                        r.immediate = imm16;
                    end
                endcase
            end
        end else if (top == STR_W_VAL || top == STR_X_VAL || top == STRH_VAL ||
                     top == STRB_VAL || top == LDR_W_VAL || top == LDR_X_VAL ||
                     top == LDR_D_VAL) begin
            case (top)
                STR_W_VAL: begin r.kind = KIND_STR;  scale = 2; end
                STR_X_VAL: begin r.kind = KIND_STR;  scale = 3; x64 = 1'b1; end
                STRH_VAL:  begin r.kind = KIND_STRH; scale = 1; end
                STRB_VAL:  begin r.kind = KIND_STRB; scale = 0; end
                LDR_W_VAL: begin r.kind = KIND_LDR;  scale = 2; end
                default:   begin r.kind = KIND_LDR;  scale = 3; x64 = 1'b1; end
            endcase
            r.decoded   = 1'b1;
            r.dest_reg  = enc_reg(w[4:0], x64, 1'b0);
            r.base_reg  = enc_reg(w[9:5], 1'b1, 1'b1);
            r.immediate = imm12 << scale;
        end else if ((w & BR_MASK) == BL_VAL || (w & BR_MASK) == B_VAL) begin
            r.decoded   = 1'b1;
            r.kind      = w[31] ? KIND_BL : KIND_B;
            r.immediate = pc + ({{38{w[25]}}, w[25:0]} << 2);
        end else if ((w & ADDSUB_MASK) == ADD_VAL || (w & ADDSUB_MASK) == SUB_VAL) begin
            r.decoded   = 1'b1;
            r.kind      = w[30] ? KIND_SUB : KIND_ADD;
            r.dest_reg  = enc_reg(w[4:0], sf, 1'b1);
            r.base_reg  = enc_reg(w[9:5], sf, 1'b1);
            r.immediate = w[22] ? (imm12 << 12) : imm12;
        end else if (top == STP_W_VAL || top == STP_X_VAL) begin
            x64          = (top == STP_X_VAL);
            off          = {{57{w[21]}}, w[21:15]};
            r.decoded    = 1'b1;
            r.kind       = KIND_STP;
            r.dest_reg   = enc_reg(w[4:0], x64, 1'b0);
            r.second_reg = enc_reg(w[14:10], x64, 1'b0);
            r.base_reg   = enc_reg(w[9:5], 1'b1, 1'b1);
            r.immediate  = off << (x64 ? 3 : 2);
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h, expected %h", n_dec_out, what, got, want);
        n_errors++;
    endtask

    task automatic add_insn(input logic [31:0] w, input logic [63:0] pc);
        insn_backlog.push_back({pc, w});
    endtask

    // ------------------------------------------------------------------------
    // driver: offers backlog beats, idles at random 18 percent of the time outside the
    // calm window; records the prediction on every accepted beat
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_fifo.push_back(decode_word(s_tdata[31:0], s_tdata[95:32]));
                n_insn_in <= n_insn_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (insn_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                    s_tdata  <= insn_backlog.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver ready: random back-pressure, plus one long hold-off once a
    // hundred beats have gone in; the sender keeps offering meanwhile, so the
    // pipeline fills and s_tready must drop
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && n_insn_in >= 100) begin
            hold_done   <= 1'b1;
            hold_cycles <= 80;
            m_tready    <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each accepted result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decode_fifo.size() == 0) begin
                flag_mismatch("unexpected beat", {59'd0, m_tuser}, '0);
            end else begin
                want = decode_fifo.pop_front();
                if (m_tuser[0] !== want.decoded)
                    flag_mismatch("decoded", m_tuser[0], want.decoded);
                if (m_tuser[4:1] !== want.kind)
                    flag_mismatch("kind", m_tuser[4:1], want.kind);
                if (m_tdata[6:0] !== want.dest_reg)
                    flag_mismatch("dest_reg", m_tdata[6:0], want.dest_reg);
                if (m_tdata[13:7] !== want.base_reg)
                    flag_mismatch("base_reg", m_tdata[13:7], want.base_reg);
                if (m_tdata[20:14] !== want.second_reg)
                    flag_mismatch("second_reg", m_tdata[20:14], want.second_reg);
                if (m_tdata[84:21] !== want.immediate)
                    flag_mismatch("immediate", m_tdata[84:21], want.immediate);
                if (m_tdata[90:85] !== want.shift_amount)
                    flag_mismatch("shift_amount", m_tdata[90:85], want.shift_amount);
                if (m_tdata[95:91] !== 5'd0)
                    flag_mismatch("tdata padding", m_tdata[95:91], '0);
            end
            n_dec_out <= n_dec_out + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] w;
        logic [63:0] pc;
        logic [31:0] top_pick;

        // directed: field extremes, every kind, and the awkward corners
        add_insn(32'h9080_001F, 64'h0000_0000_0000_0ABC); // ADRP most negative, wraps down
        add_insn(32'hF07F_FFE5, 64'hFFFF_FFFF_FFFF_FFFF); // ADRP most positive, wraps up
        add_insn(32'hAA02_03E1, 64'h0);                   // MOV x1, x2
        add_insn(32'h2A1F_03FF, 64'h0);                   // MOV wzr, wzr
        add_insn(32'h2A02_07E1, 64'h0);                   // ORR with a shift: not the alias
        add_insn(32'hD2FF_FFE0, 64'h0);                   // MOVZ x, top halfword
        add_insn(32'h52E2_4681, 64'h0);                   // MOVZ w with hw 3, unmasked
        add_insn(32'h9280_0000, 64'h0);                   // MOVN x, #0 -> all ones
        add_insn(32'h12D5_79A2, 64'h0);                   // MOVN w with hw 2
        add_insn(32'hF2AA_AAA3, 64'h0);                   // MOVK x, hw 1
        add_insn(32'h3280_0000, 64'h0);                   // move-wide opc 01, 32-bit
        add_insn(32'hB281_2345, 64'h0);                   // move-wide opc 01, 64-bit
        add_insn(32'hB93F_FFFF, 64'h0);                   // STR w, SP base, top offset
        add_insn(32'hF900_0421, 64'h0);                   // STR x
        add_insn(32'h7900_0C5F, 64'h0);                   // STRH
        add_insn(32'h393F_FC00, 64'h0);                   // STRB
        add_insn(32'hB940_0BE0, 64'h0);                   // LDR w
        add_insn(32'hF940_0FE8, 64'h0);                   // LDR x
        add_insn(32'hFD40_0421, 64'h0);                   // LDR d form
        add_insn(32'h9600_0000, 64'h0000_0000_0000_0010); // BL most negative, wraps
        add_insn(32'h15FF_FFFF, 64'hFFFF_FFFF_FFFF_FF00); // B most positive, wraps
        add_insn(32'h913F_FFFF, 64'h0);                   // ADD sp, sp, #0xfff
        add_insn(32'h1140_0421, 64'h0);                   // ADD w, shifted by 12
        add_insn(32'h517F_FC00, 64'h0);                   // SUB w, shifted, top imm
        add_insn(32'hA93F_7BFD, 64'h0);                   // STP x29, x30, [sp, #-16]
        add_insn(32'h291F_8441, 64'h0);                   // STP w, most positive offset
        add_insn(32'h0000_0000, 64'h0);                   // nothing matches
        add_insn(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // nothing matches, all ones

        // random: mostly well-formed words with random fields, rest noise
        repeat (400) begin
            case ($urandom_range(0, 3))
                0:       pc = {$urandom, $urandom};
                1:       pc = {32'hFFFF_FFFF, $urandom};
                2:       pc = {32'd0, $urandom};
                default: pc = {$urandom, $urandom} | 64'hFFFF_FFFF_FFF0_0000;
            endcase
            w = $urandom;
            case ($urandom_range(0, 8))
                0: w = {1'b1, w[30:29], 5'b10000, w[23:0]};                  // ADRP
                1: w = {w[31], 10'b0101010000, w[20:16], 6'd0, 5'd31, w[4:0]}; // MOV
                2: w = {w[31:29], 6'b100101, w[22:0]};                       // move-wide
                3: begin                                                     // load/store
                    case ($urandom_range(0, 6))
                        0:       top_pick = STR_W_VAL;
                        1:       top_pick = STR_X_VAL;
                        2:       top_pick = STRH_VAL;
                        3:       top_pick = STRB_VAL;
                        4:       top_pick = LDR_W_VAL;
                        5:       top_pick = LDR_X_VAL;
                        default: top_pick = LDR_D_VAL;
                    endcase
                    w = top_pick | (w & ~TOP_MASK);
                end
                4: w = {w[31], 5'b00101, w[25:0]};                           // B / BL
                5: w = {w[31:30], 7'b0100010, w[22:0]};                      // ADD / SUB
                6: w = {w[31], 9'b010100100, w[21:0]};                       // STP
                default: ;                                                   // noise
            endcase
            add_insn(w, pc);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (insn_backlog.size() != 0 || s_tvalid || decode_fifo.size() != 0)
            @(posedge aclk);
        // two-stage pipe: a few spare cycles catch any stray beat
        repeat (8) @(posedge aclk);

        if (decode_fifo.size() != 0)
            flag_mismatch("results never arrived", decode_fifo.size(), '0);

        if (n_errors == 0) begin
            $display("arm64_instruction_subset_decoder_top verification clean");
        end else begin
            $display("arm64_instruction_subset_decoder_top verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #600000;
        $display("arm64_instruction_subset_decoder_top verification failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
design/a64dec_pkg.sv
design/arm64_instruction_subset_decoder_top.sv
test/tb.sv
